// ===== hw/rtl/ecp_pkg.sv =====
// Shared types and constants of the exclusive call-time profiler.
// No dependencies; ecp_ifs, ecp_seq and the core import this package.
package ecp_pkg;

	localparam int ID_W     = 8;
	localparam int TS_W     = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ENTER = 2'd0,
		OP_EXIT  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_FAULT    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} seq_state_t;

	typedef struct packed {
		logic clearing;
		logic idle;
		logic exec;
	} seq_ctl_t;

endpackage

// ===== hw/rtl/ecp_ifs.sv =====
// Valid/ready channel interfaces for trace requests and profiler results.
// Depends on ecp_pkg for the field widths.
interface ecp_evt_if import ecp_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   func_id;
	logic [TS_W-1:0]   timestamp;

	modport source(output valid, op, func_id, timestamp, input ready);
	modport sink(input valid, op, func_id, timestamp, output ready);
endinterface

interface ecp_res_if import ecp_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_func_id;
	logic [TS_W-1:0]     call_time;
	logic [TS_W-1:0]     total_time;

	modport source(output valid, status, out_func_id, call_time, total_time, input ready);
	modport sink(input valid, status, out_func_id, call_time, total_time, output ready);
endinterface

// ===== hw/rtl/ecp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ecp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/ecp_seq.sv =====
// Sequencer of the profiler: clearing sweep of the totals table, then the
// idle/execute cycle of each request. Depends on ecp_pkg.
module ecp_seq import ecp_pkg::*; #(
	parameter int FUNC_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          out_free,
	output seq_ctl_t                      ctl,
	output logic [$clog2(FUNC_COUNT)-1:0] clr_addr
);

	localparam int SW = $clog2(FUNC_COUNT);

	seq_state_t      state_q, state_d;
	logic [SW-1:0]   clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clearing = 1'b1;
				if (clr_cnt_q == SW'(FUNC_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign clr_addr = clr_cnt_q;

endmodule

// ===== hw/rtl/exclusive_call_time_profiler_core.sv =====
// Top level of the exclusive call-time profiler.
// Depends on ecp_pkg, ecp_ifs (channels), ecp_ram and ecp_seq.
//
// Usage: trace requests (enter, exit, or read of a function's total) arrive on
// the evt channel; one result per request leaves on the res channel. Both are
// valid/ready channels; a request moves when valid and ready are high together.
// The call stack lives in a RAM of STACK_DEPTH entries, with the top entry held
// in registers, and the per-function totals live in a RAM of FUNC_COUNT entries.
// For each request the stack entry below the top and the function's total
// are read at the accepting edge; in the execute state that follows, the top
// is updated, the stack is pushed or popped, on a matching exit the total is
// written back, and the result register is loaded. A new request is taken
// only in the idle state, so not before the previous one has executed, as
// the two RAMs have a registered read.
// After reset the block sweeps the totals RAM to zero, one entry per cycle,
// over all FUNC_COUNT entries; evt.ready stays low during that sweep.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted, and its execute cycle holds until the register
// frees up. A malformed trace sets a sticky fault that holds until reset.
module exclusive_call_time_profiler_core import ecp_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int FUNC_COUNT  = 256,
	parameter int TIME_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ecp_evt_if.sink   evt,
	ecp_res_if.source res
);

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int SW    = $clog2(FUNC_COUNT);
	localparam int SE_W  = ID_W + TIME_BITS;

	// Table slot of an id: id modulo FUNC_COUNT by restoring subtraction, one
	// step per id bit.
	function automatic logic [SW-1:0] slot_of(input logic [ID_W-1:0] id);
		int unsigned v;
		v = 32'(id);
		for (int k = ID_W - 1; k >= 0; k--) begin
			if (v >= (32'(FUNC_COUNT) << k)) begin
				v = v - (32'(FUNC_COUNT) << k);
			end
		end
		return SW'(v);
	endfunction

	// Saturating add of two time values.
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	// Sequencer.
	seq_ctl_t      ctl;
	logic [SW-1:0] clr_addr;
	logic          accept;
	logic          out_free;
	logic          exec_fire;

	assign evt.ready = ctl.idle;
	assign accept    = evt.valid && evt.ready;
	assign out_free  = !res.valid || res.ready;
	assign exec_fire = ctl.exec && out_free;

	ecp_seq #(
		.FUNC_COUNT(FUNC_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.ctl      (ctl),
		.clr_addr (clr_addr)
	);

	// Request captured at acceptance.
	logic [OP_W-1:0]      op_s1;
	logic [ID_W-1:0]      id_s1;
	logic [TIME_BITS-1:0] ts_s1;
	logic [SW-1:0]        slot_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= evt.op;
			id_s1   <= evt.func_id;
			ts_s1   <= TIME_BITS'(evt.timestamp);
			slot_s1 <= slot_of(evt.func_id);
		end
	end

	// Profiler state kept in registers.
	logic [LVL_W-1:0]     level_q;
	logic [TIME_BITS-1:0] prev_q;
	logic                 fault_q;
	logic [ID_W-1:0]      top_id_q;
	logic [TIME_BITS-1:0] top_time_q;

	// Stack RAM: holds every entry below the top one.
	logic            stk_we;
	logic [AW-1:0]   stk_waddr;
	logic [SE_W-1:0] stk_wdata;
	logic [AW-1:0]   stk_raddr;
	logic [SE_W-1:0] stk_rdata;
	logic [LVL_W-1:0] lvl_m1;
	logic [LVL_W-1:0] lvl_m2;

	assign lvl_m1    = level_q - 1'b1;
	assign lvl_m2    = level_q - 2'd2;
	assign stk_waddr = lvl_m1[AW-1:0];
	assign stk_raddr = lvl_m2[AW-1:0];

	ecp_ram #(
		.WIDTH(SE_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Totals RAM, zeroed by the sweep after reset.
	logic                 tot_wr;
	logic                 tot_we;
	logic [SW-1:0]        tot_waddr;
	logic [TIME_BITS-1:0] tot_wdata;
	logic [TIME_BITS-1:0] tot_rdata;
	logic [TIME_BITS-1:0] tot_new;

	assign tot_we    = ctl.clearing || (exec_fire && tot_wr);
	assign tot_waddr = ctl.clearing ? clr_addr : slot_s1;
	assign tot_wdata = ctl.clearing ? '0 : tot_new;

	ecp_ram #(
		.WIDTH(TIME_BITS),
		.DEPTH(FUNC_COUNT)
	) u_totals_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_waddr),
		.wdata (tot_wdata),
		.re    (accept),
		.raddr (slot_of(evt.func_id)),
		.rdata (tot_rdata)
	);

	// Execute-cycle logic.
	logic                 is_event;
	logic [TIME_BITS-1:0] delta;
	logic [TIME_BITS-1:0] top_upd;
	logic [TIME_BITS-1:0] call;
	logic [TIME_BITS-1:0] total_out;
	status_t              status;
	logic                 set_fault;
	logic                 push;
	logic                 pop;

	always_comb begin
		is_event  = ((op_s1 == OP_ENTER) || (op_s1 == OP_EXIT)) && !fault_q;
		delta     = ts_s1 - prev_q;
		top_upd   = (level_q != '0) ? sat_add(top_time_q, delta) : top_time_q;
		status    = fault_q ? ST_FAULT : ST_OK;
		call      = '0;
		tot_wr    = 1'b0;
		set_fault = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		stk_we    = 1'b0;
		stk_wdata = {top_id_q, top_upd};
		tot_new   = sat_add(tot_rdata, top_upd);
		if (is_event) begin
			if (op_s1 == OP_ENTER) begin
				if (level_q == LVL_W'(STACK_DEPTH)) begin
					status    = ST_OVERFLOW;
					set_fault = 1'b1;
				end else begin
					push   = 1'b1;
					// The old top moves down into the RAM.
					stk_we = exec_fire && (level_q != '0);
				end
			end else begin
				if (level_q == '0) begin
					status    = ST_EMPTY;
					set_fault = 1'b1;
				end else if (top_id_q != id_s1) begin
					status    = ST_MISMATCH;
					set_fault = 1'b1;
				end else begin
					pop    = 1'b1;
					call   = top_upd;
					tot_wr = 1'b1;
				end
			end
		end
		total_out = tot_wr ? tot_new : tot_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			prev_q  <= '0;
			fault_q <= 1'b0;
		end else if (exec_fire && is_event) begin
			prev_q  <= ts_s1;
			fault_q <= set_fault;
			if (push) begin
				level_q <= level_q + 1'b1;
			end else if (pop) begin
				level_q <= lvl_m1;
			end
		end
	end

	// The top entry needs no reset: it is only read while the stack is not empty.
	always_ff @(posedge clk) begin
		if (exec_fire && is_event) begin
			if (push) begin
				top_id_q   <= id_s1;
				top_time_q <= '0;
			end else if (pop) begin
				// The entry just below becomes the top; it came out of the RAM
				// at the accepting edge.
				if (level_q > LVL_W'(1)) begin
					top_id_q   <= stk_rdata[SE_W-1:TIME_BITS];
					top_time_q <= stk_rdata[TIME_BITS-1:0];
				end
			end else begin
				top_time_q <= top_upd;
			end
		end
	end

	// Output register.
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [TS_W-1:0]     res_call_q;
	logic [TS_W-1:0]     res_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			res_status_q <= status;
			res_id_q     <= id_s1;
			res_call_q   <= TS_W'(call);
			res_total_q  <= TS_W'(total_out);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = res_status_q;
	assign res.out_func_id = res_id_q;
	assign res.call_time   = res_call_q;
	assign res.total_time  = res_total_q;

`ifndef SYNTH
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond stack depth");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault flag cleared without reset");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !evt.ready)
		else $error("request accepted during totals sweep");

	a_fault_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_FAULT) |-> fault_q)
		else $error("fault status reported without fault flag");
`endif

endmodule
